/* rtl/assert_macros.svh */
// Assertion helpers for the noise oscillator. Both sample on clk and stay
// quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/nno_pkg.sv */
package nno_pkg;

  localparam int TABLE_SIZE      = 256;
  localparam int IDX_W           = $clog2(TABLE_SIZE);
  localparam int PHASE_FRAC_BITS = 24;
  localparam int QF              = 24;                    // noise fraction bits
  localparam int SPD_SHIFT       = QF - PHASE_FRAC_BITS;  // Q.24 speed to phase LSBs

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KNOB = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIX  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_KNOB  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MIX   = 8'd3;

  localparam logic [17:0] RST_SPEED_KNOB = 18'd125913;
  localparam logic [16:0] RST_SPEED_MIX  = 17'd32768;
  localparam logic [15:0] RST_GAIN_KNOB  = 16'd4096;
  localparam logic [16:0] RST_GAIN_MIX   = 17'd32768;

  localparam logic [24:0] ONE_Q      = 25'h100_0000;        // 1.0 in Q.24
  localparam logic [23:0] RECIP3     = 24'hAA_AAAB;         // ceil(2^25/3)
  localparam logic [27:0] RECIP15    = 28'd143165577;       // ceil(2^31/15)
  localparam logic [20:0] OUT_MAX    = 21'h0F_FFFF;
  localparam logic [20:0] OUT_MIN    = 21'h10_0000;

  // Lattice sequence: steps 0..8 run the falloff, 9 and 10 accumulate terms.
  localparam logic [3:0] LAT_TERM0 = 4'd9;
  localparam logic [3:0] LAT_TERM1 = 4'd10;

  typedef struct packed {
    logic [17:0] speed_knob;
    logic [16:0] speed_mix;
    logic [15:0] gain_knob;
    logic [16:0] gain_mix;
  } cfg_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic signed [20:0] noise_out;
  } core_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LAT,
    ST_GAIN_A,
    ST_GAIN_B,
    ST_GAIN_C,
    ST_GAIN_D,
    ST_OUT_A,
    ST_OUT_B,
    ST_SPD_B,
    ST_SPD_C,
    ST_SPD_D,
    ST_SPD_E,
    ST_DONE
  } st_t;

  localparam logic [7:0] PERM [TABLE_SIZE] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

/* rtl/nno_mul.sv */
module nno_mul (
  input  logic                                clk,
  input  logic signed [nno_pkg::MUL_W-1:0]    a,
  input  logic signed [nno_pkg::MUL_W-1:0]    b,
  output logic signed [nno_pkg::PROD_W-1:0]   p
);

  // One signed product per cycle, registered.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/nno_core.sv */
module nno_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [15:0]        speed_cv,
  input  logic signed [15:0]        gain_cv,
  input  nno_pkg::cfg_t             cfg,
  input  logic                      res_ready,
  output nno_pkg::core_stat_t       stat
);

  nno_pkg::st_t st_r, st_nxt;
  logic [3:0]   step_r, step_nxt;
  logic         pass_r, pass_nxt;
  logic [31:0]  phase_r, phase_nxt;

  logic signed [15:0] scv_r, scv_nxt;
  logic signed [15:0] gcv_r, gcv_nxt;
  logic [24:0]        ax0_r, ax0_nxt, ax1_r, ax1_nxt;
  logic [24:0]        t0_r, t0_nxt, t1_r, t1_nxt;
  logic [7:0]         h0_r, h0_nxt, h1_r, h1_nxt;
  logic signed [28:0] acc_r, acc_nxt;
  logic signed [26:0] n_r, n_nxt;
  logic signed [24:0] gain_r, gain_nxt;
  logic signed [47:0] num_r, num_nxt;
  logic               neg_r, neg_nxt;
  logic signed [20:0] y_r, y_nxt;

  logic signed [nno_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [nno_pkg::PROD_W-1:0] prod;
  logic                              done;

  // Lattice split of the current noise argument.
  logic signed [32:0]              nx;
  logic [nno_pkg::IDX_W-1:0]       ix, ix_p1;
  logic [23:0]                     x0;

  // Lattice datapath helpers.
  logic        lane;
  logic [24:0] tsel, axsel, gsel, prod_hi, t_store;
  logic [3:0]  g0, g1;
  logic signed [28:0] term_u, term_s, sum29;
  logic        term_neg;

  // Output, gain and speed helpers.
  logic [21:0]        y_hi;
  logic [15:0]        gabs;
  logic [22:0]        gq;
  logic [24:0]        k120;
  logic signed [17:0] smix_d;
  logic signed [28:0] sv;
  logic [27:0]        svm;
  logic [24:0]        sq;
  logic signed [25:0] spd;

  nno_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign nx    = 33'(n_r);
  assign ix    = pass_r ? nx[nno_pkg::QF+nno_pkg::IDX_W-1:nno_pkg::QF]
                        : phase_r[nno_pkg::PHASE_FRAC_BITS+nno_pkg::IDX_W-1:
                                  nno_pkg::PHASE_FRAC_BITS];
  assign ix_p1 = ix + nno_pkg::IDX_W'(1);
  assign x0    = pass_r ? nx[nno_pkg::QF-1:0]
                        : 24'(phase_r[nno_pkg::PHASE_FRAC_BITS-1:0]) << nno_pkg::SPD_SHIFT;

  assign lane    = step_r[0];
  assign g0      = {1'b0, h0_r[2:0]} + 4'd1;
  assign g1      = {1'b0, h1_r[2:0]} + 4'd1;
  assign tsel    = lane ? t1_r : t0_r;
  assign axsel   = lane ? ax1_r : ax0_r;
  assign gsel    = lane ? 25'(g1) : 25'(g0);
  assign prod_hi = prod[48:24];
  assign t_store = (step_r < 4'd3) ? (nno_pkg::ONE_Q - prod_hi) : prod_hi;
  assign term_u  = signed'({1'b0, prod[27:0]});
  // Second point sits at x-1, always negative, so its sign flips.
  assign term_neg = (step_r == nno_pkg::LAT_TERM0) ? h0_r[3] : !h1_r[3];
  assign term_s   = term_neg ? -term_u : term_u;
  assign sum29    = acc_r + term_s;

  assign y_hi   = prod[65:44];
  assign gabs   = gcv_r[15] ? 16'(-gcv_r) : 16'(gcv_r);
  assign gq     = prod[47:25];
  assign k120   = (25'(cfg.speed_knob) << 7) - (25'(cfg.speed_knob) << 3);
  assign smix_d = 18'sd65536 - signed'({1'b0, cfg.speed_mix});
  assign sv     = signed'(num_r[47:19]);
  assign svm    = num_r[47] ? 28'(29'sd14 - sv) : 28'(sv);
  assign sq     = prod[55:31];
  assign spd    = neg_r ? -26'(sq) : 26'(sq);

  always_comb begin
    st_nxt    = st_r;
    step_nxt  = step_r;
    pass_nxt  = pass_r;
    phase_nxt = phase_r;
    scv_nxt   = scv_r;
    gcv_nxt   = gcv_r;
    ax0_nxt   = ax0_r;
    ax1_nxt   = ax1_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    h0_nxt    = h0_r;
    h1_nxt    = h1_r;
    acc_nxt   = acc_r;
    n_nxt     = n_r;
    gain_nxt  = gain_r;
    num_nxt   = num_r;
    neg_nxt   = neg_r;
    y_nxt     = y_r;
    mul_a     = '0;
    mul_b     = '0;
    done      = 1'b0;
    unique case (st_r)
      nno_pkg::ST_IDLE: begin
        if (start) begin
          scv_nxt  = speed_cv;
          gcv_nxt  = gain_cv;
          pass_nxt = 1'b0;
          st_nxt   = nno_pkg::ST_SETUP;
        end
      end
      nno_pkg::ST_SETUP: begin
        ax0_nxt  = {1'b0, x0};
        ax1_nxt  = nno_pkg::ONE_Q - {1'b0, x0};
        h0_nxt   = nno_pkg::PERM[ix];
        h1_nxt   = nno_pkg::PERM[ix_p1];
        step_nxt = '0;
        st_nxt   = nno_pkg::ST_LAT;
      end
      nno_pkg::ST_LAT: begin
        // Both lattice points alternate on the multiplier.
        mul_a = (step_r < 4'd2) ? 33'(axsel) : 33'(tsel);
        if (step_r < 4'd2 || (step_r > 4'd5 && step_r < 4'd8)) begin
          mul_b = 33'(axsel);
        end else if (step_r < 4'd6) begin
          mul_b = 33'(tsel);
        end else begin
          mul_b = 33'(gsel);
        end
        if (step_r != 4'd0 && step_r < nno_pkg::LAT_TERM0) begin
          if (step_r[0]) begin
            t0_nxt = t_store;
          end else begin
            t1_nxt = t_store;
          end
        end
        step_nxt = step_r + 4'd1;
        if (step_r == nno_pkg::LAT_TERM0) begin
          acc_nxt = term_s;
        end
        if (step_r == nno_pkg::LAT_TERM1) begin
          n_nxt = 27'(sum29 >>> 2);
          if (pass_r) begin
            st_nxt = nno_pkg::ST_GAIN_A;
          end else begin
            pass_nxt = 1'b1;
            st_nxt   = nno_pkg::ST_SETUP;
          end
        end
      end
      nno_pkg::ST_GAIN_A: begin
        if (gcv_r == 16'sd0) begin
          gain_nxt = signed'(25'(cfg.gain_knob) << 4);
          st_nxt   = nno_pkg::ST_OUT_A;
        end else begin
          mul_a  = 33'(cfg.gain_knob);
          mul_b  = 33'(gabs);
          st_nxt = nno_pkg::ST_GAIN_B;
        end
      end
      nno_pkg::ST_GAIN_B: begin
        mul_a  = 33'(prod[31:0]);
        mul_b  = 33'(18'(cfg.gain_mix) + 18'h1_0000);
        st_nxt = nno_pkg::ST_GAIN_C;
      end
      nno_pkg::ST_GAIN_C: begin
        mul_a  = 33'(prod[48:25]);
        mul_b  = 33'(nno_pkg::RECIP3);
        st_nxt = nno_pkg::ST_GAIN_D;
      end
      nno_pkg::ST_GAIN_D: begin
        gain_nxt = gcv_r[15] ? -signed'(25'(gq)) : signed'(25'(gq));
        st_nxt   = nno_pkg::ST_OUT_A;
      end
      nno_pkg::ST_OUT_A: begin
        mul_a  = 33'(n_r);
        mul_b  = 33'(gain_r);
        st_nxt = nno_pkg::ST_OUT_B;
      end
      nno_pkg::ST_OUT_B: begin
        if ((&y_hi) || !(|y_hi)) begin
          y_nxt = signed'(prod[44:24]);
        end else begin
          y_nxt = prod[65] ? signed'(nno_pkg::OUT_MIN) : signed'(nno_pkg::OUT_MAX);
        end
        if (scv_r == 16'sd0) begin
          phase_nxt = phase_r + 32'(cfg.speed_knob >> nno_pkg::SPD_SHIFT);
          st_nxt    = nno_pkg::ST_DONE;
        end else begin
          mul_a  = 33'(scv_r);
          mul_b  = 33'(cfg.speed_mix);
          st_nxt = nno_pkg::ST_SPD_B;
        end
      end
      nno_pkg::ST_SPD_B: begin
        num_nxt = signed'({prod[34:0], 13'b0});
        mul_a   = 33'(k120);
        mul_b   = 33'(smix_d);
        st_nxt  = nno_pkg::ST_SPD_C;
      end
      nno_pkg::ST_SPD_C: begin
        num_nxt = num_r + 48'(prod);
        st_nxt  = nno_pkg::ST_SPD_D;
      end
      nno_pkg::ST_SPD_D: begin
        neg_nxt = num_r[47];
        mul_a   = 33'(svm);
        mul_b   = 33'(nno_pkg::RECIP15);
        st_nxt  = nno_pkg::ST_SPD_E;
      end
      nno_pkg::ST_SPD_E: begin
        phase_nxt = phase_r + 32'(spd >>> nno_pkg::SPD_SHIFT);
        st_nxt    = nno_pkg::ST_DONE;
      end
      nno_pkg::ST_DONE: begin
        if (res_ready) begin
          done   = 1'b1;
          st_nxt = nno_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = nno_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= nno_pkg::ST_IDLE;
      step_r  <= '0;
      pass_r  <= 1'b0;
      phase_r <= '0;
    end else begin
      st_r    <= st_nxt;
      step_r  <= step_nxt;
      pass_r  <= pass_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scv_r  <= scv_nxt;
    gcv_r  <= gcv_nxt;
    ax0_r  <= ax0_nxt;
    ax1_r  <= ax1_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    h0_r   <= h0_nxt;
    h1_r   <= h1_nxt;
    acc_r  <= acc_nxt;
    n_r    <= n_nxt;
    gain_r <= gain_nxt;
    num_r  <= num_nxt;
    neg_r  <= neg_nxt;
    y_r    <= y_nxt;
  end

  assign stat.idle      = (st_r == nno_pkg::ST_IDLE);
  assign stat.done      = done;
  assign stat.noise_out = y_r;

endmodule

/* rtl/nested_noise_oscillator.sv */
// Nested gradient-noise oscillator: each input beat (speed CV, gain CV, both
// signed Q5.11, zero meaning "not patched") yields one output beat holding
// noise(noise(phase)) times the gain, signed Q.16, saturated to 21 bits; the
// phase then advances by the knob speed or by the CV/knob mix. The block works
// on one sample at a time: two noise evaluations, then the gain and output
// product, then the CV speed mix when the speed CV is patched, plus hand-off.
// All of these share the single 33x33 multiplier, which delivers one registered
// product per cycle. Take in_ready as the only indication of when the next
// sample may enter; a finished sample waits in the output register while the
// next one is already being computed. Write the configuration registers only
// while no sample is in flight.
`include "assert_macros.svh"

module nested_noise_oscillator (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                in_speed_cv,
  input  logic signed [15:0]                in_gain_cv,
  // sample output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [20:0]                out_noise_out,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nno_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nno_pkg::CFG_DATA_W-1:0]    cfg_data
);

  nno_pkg::cfg_t       cfg_r;
  nno_pkg::core_stat_t core_stat;
  logic                out_valid_r;
  logic signed [20:0]  out_noise_r;
  logic                start;
  logic                res_ready;

  // Register writes are always taken; upper data bits are dropped, unknown
  // indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_knob <= nno_pkg::RST_SPEED_KNOB;
      cfg_r.speed_mix  <= nno_pkg::RST_SPEED_MIX;
      cfg_r.gain_knob  <= nno_pkg::RST_GAIN_KNOB;
      cfg_r.gain_mix   <= nno_pkg::RST_GAIN_MIX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nno_pkg::CFG_SPEED_KNOB: cfg_r.speed_knob <= cfg_data[17:0];
        nno_pkg::CFG_SPEED_MIX:  cfg_r.speed_mix  <= cfg_data[16:0];
        nno_pkg::CFG_GAIN_KNOB:  cfg_r.gain_knob  <= cfg_data[15:0];
        nno_pkg::CFG_GAIN_MIX:   cfg_r.gain_mix   <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  // Accept a new sample whenever the sequencer is idle, even if the previous
  // result is still sitting in the output register.
  assign in_ready = core_stat.idle;
  assign start    = in_valid && in_ready;

  // The sequencer may only hand over a result when the output slot is free or
  // being emptied in this very cycle.
  assign res_ready = !out_valid_r || out_ready;

  nno_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .speed_cv  (in_speed_cv),
    .gain_cv   (in_gain_cv),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .stat      (core_stat)
  );

  // Output register: load on hand-over, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_stat.done) begin
      out_noise_r <= core_stat.noise_out;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_noise_out = out_noise_r;

  // A hand-over never overwrites a result that is still waiting.
  `ASSERT_IMP(a_done_slot_free, core_stat.done, !out_valid_r || out_ready,
              "result handed over while output register still full")
  // An accepted sample starts the sequencer right away.
  `ASSERT_NXT(a_start_busy, in_valid && in_ready, !core_stat.idle,
              "sequencer stayed idle after an accepted sample")
  // A new output beat only appears after a hand-over.
  `ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(core_stat.done),
              "output valid rose without a hand-over")

endmodule
